// ===== hdl/swaf_pkg.sv =====
`timescale 1ns / 1ps
package swaf_pkg;

	localparam int SampleW = 24;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 24;

	localparam logic [CfgIdxW-1:0] CFG_WINDOW_LENGTH = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_BIG_MOVE_LIMIT = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_MIN_RANGE = 2'd3;

	localparam logic [6:0] WL_RESET = 7'd20;
	localparam logic [23:0] THR_RESET = 24'd131072;
	localparam logic [22:0] BML_RESET = 23'd6554;
	localparam logic [23:0] MINR_RESET = 24'd66;
	localparam logic [24:0] THR_ONE = 25'd65536;

	typedef enum logic [1:0] {
		CAUSE_NONE = 2'd0,
		CAUSE_RANGE = 2'd1,
		CAUSE_ZSCORE = 2'd2,
		CAUSE_BIG = 2'd3
	} cause_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAVE,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_OLD,
		OP_XX,
		OP_RANGE,
		OP_NSQ,
		OP_S2,
		OP_NX,
		OP_D2,
		OP_T2,
		OP_RHS
	} op_t;

	typedef struct packed {
		logic has;
		logic signed [SampleW-1:0] mx;
		logic signed [SampleW-1:0] mn;
		logic signed [SampleW-1:0] oldv;
	} wave_t;

endpackage

// ===== hdl/swaf_in_if.sv =====
`timescale 1ns / 1ps
interface swaf_in_if;
	logic valid;
	logic ready;
	logic signed [23:0] sample;
	logic start_series;
	modport source(output valid, output sample, output start_series, input ready);
	modport sink(input valid, input sample, input start_series, output ready);
endinterface

// ===== hdl/swaf_out_if.sv =====
`timescale 1ns / 1ps
interface swaf_out_if;
	logic valid;
	logic ready;
	logic anomaly;
	logic [1:0] cause;
	modport source(output valid, output anomaly, output cause, input ready);
	modport sink(input valid, input anomaly, input cause, output ready);
endinterface

// ===== hdl/sliding_window_anomaly_flagger.sv =====
`timescale 1ns / 1ps
// Flags outliers in a stream of signed Q8.16 samples against a window of up to DEPTH-1 earlier
// samples, held in a shift chain of cells. One item is in flight at a time, and a finished result
// waits in an output register so that the next item can start. Once an item is accepted, the
// minimum, maximum and oldest sample ripple down the cell chain. It then runs a series of products
// through one shift-and-add multiplier, where each product runs until its second operand has
// shifted down to zero. Without a test only the squares of the oldest and the new sample are
// formed; otherwise a range test and, unless an earlier step decides, a z-score test follow. A
// final state hands the result to the output register. While an earlier result is still waiting,
// the item holds in that final state.
module sliding_window_anomaly_flagger
	import swaf_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	swaf_in_if.sink samples,
	swaf_out_if.source results,
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [CfgDataW-1:0] cfg_data
);

	localparam int NW = $clog2(DEPTH + 1);
	localparam int SW = SampleW + NW;
	localparam int SQW = 2 * SampleW - 2 + NW;
	localparam int VW = SQW + NW;
	localparam int DW = SW + 1;
	localparam int BW = 50;
	localparam int PW = VW + BW;

	state_t state_q, state_d;
	op_t op_q;
	logic launch_q;
	logic [NW-1:0] cnt_q;

	logic [6:0] wl_q;
	logic [23:0] thr_q;
	logic [22:0] bml_q;
	logic [23:0] minr_q;

	logic signed [SampleW-1:0] x_q;
	logic [NW-1:0] fill_q;
	logic signed [SW-1:0] sum_q;
	logic [SQW-1:0] sumsq_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] oldi_q;
	logic drop_q;
	logic test_q;
	logic signed [SW-1:0] sum_a_q;
	logic [SQW-1:0] sumsq_a_q;
	logic [SQW-1:0] xsq_q;
	logic [SampleW-1:0] oldm_q;
	logic signed [SampleW-1:0] mx_q;
	logic signed [SampleW-1:0] mn_q;
	logic [VW-1:0] nsq_q;
	logic [VW-1:0] v_q;
	logic [DW-1:0] d_q;
	logic [2*DW-1:0] lhs_q;
	logic [BW-1:0] t2_q;
	cause_t cause_q;
	logic out_valid_q;
	logic out_anomaly_q;
	logic [1:0] out_cause_q;

	logic [NW-1:0] len;
	logic [NW-1:0] fill_w;
	logic drop_w;
	logic [NW-1:0] nfill_w;
	logic [SampleW-1:0] xm;
	logic big;
	logic [SW-1:0] sum_mag;
	logic signed [SampleW:0] span_s;
	logic [SampleW-1:0] span;
	logic above;
	logic below;
	logic rcond;
	logic [SampleW:0] ext;
	logic range_hit;
	logic [24:0] t1;
	logic signed [SW:0] nxs;
	logic signed [SW:0] diff;
	logic out_free;
	logic push;

	logic mul_start;
	logic mul_busy;
	logic [PW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic [PW-1:0] prod;
	logic mul_done;

	logic signed [SampleW-1:0] chain [DEPTH+1];
	wave_t wv [DEPTH+1];

	always_comb begin
		if (wl_q < 7'd2) begin
			len = NW'(2);
		end else if (32'(wl_q) > DEPTH) begin
			len = NW'(DEPTH);
		end else begin
			len = NW'(wl_q);
		end
	end

	assign fill_w = samples.start_series ? '0 : fill_q;
	assign drop_w = fill_w >= len;
	assign nfill_w = fill_w - NW'(drop_w);

	assign xm = x_q[SampleW-1] ? SampleW'(-x_q) : SampleW'(x_q);
	assign big = xm > {1'b0, bml_q};
	assign sum_mag = sum_a_q[SW-1] ? SW'(-sum_a_q) : SW'(sum_a_q);
	assign span_s = (SampleW+1)'(mx_q) - (SampleW+1)'(mn_q);
	assign span = span_s[SampleW-1:0];
	assign above = x_q > mx_q;
	assign below = x_q < mn_q;
	assign rcond = (span > minr_q) && (above || below);
	assign ext = above ? (SampleW+1)'((SampleW+1)'(x_q) - (SampleW+1)'(mx_q))
		: (SampleW+1)'((SampleW+1)'(mn_q) - (SampleW+1)'(x_q));
	assign range_hit = rcond && (PW'({ext, 16'b0}) > prod);
	assign t1 = {1'b0, thr_q} + THR_ONE;
	assign nxs = x_q[SampleW-1] ? -(SW+1)'(prod[SW-1:0]) : (SW+1)'(prod[SW-1:0]);
	assign diff = nxs - (SW+1)'(sum_a_q);
	assign out_free = !out_valid_q || results.ready;
	assign mul_start = (state_q == ST_MUL) && launch_q;
	assign mul_done = (state_q == ST_MUL) && !launch_q && !mul_busy;
	assign push = (state_q == ST_FIN) && out_free;

	always_comb begin
		case (op_q)
			OP_OLD: begin
				mul_a = PW'(oldm_q);
				mul_b = BW'(oldm_q);
			end
			OP_XX: begin
				mul_a = PW'(xm);
				mul_b = BW'(xm);
			end
			OP_RANGE: begin
				mul_a = PW'(thr_q);
				mul_b = rcond ? BW'(span) : '0;
			end
			OP_NSQ: begin
				mul_a = PW'(sumsq_a_q);
				mul_b = BW'(n_q);
			end
			OP_S2: begin
				mul_a = PW'(sum_mag);
				mul_b = BW'(sum_mag);
			end
			OP_NX: begin
				mul_a = PW'(xm);
				mul_b = BW'(n_q);
			end
			OP_D2: begin
				mul_a = PW'(d_q);
				mul_b = BW'(d_q);
			end
			OP_T2: begin
				mul_a = PW'(t1);
				mul_b = BW'(t1);
			end
			OP_RHS: begin
				mul_a = PW'(v_q);
				mul_b = t2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (samples.valid) begin
					state_d = ST_WAVE;
				end
			end
			ST_WAVE: begin
				if (cnt_q == NW'(DEPTH)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					case (op_q)
						OP_XX: begin
							if (!test_q) begin
								state_d = ST_FIN;
							end
						end
						OP_RANGE: begin
							if (range_hit) begin
								state_d = ST_FIN;
							end
						end
						OP_S2: begin
							if (nsq_q == prod[VW-1:0]) begin
								state_d = ST_FIN;
							end
						end
						OP_RHS: begin
							state_d = ST_FIN;
						end
						default: begin
						end
					endcase
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_OLD;
			launch_q <= 1'b0;
			cnt_q <= '0;
			wl_q <= WL_RESET;
			thr_q <= THR_RESET;
			bml_q <= BML_RESET;
			minr_q <= MINR_RESET;
			fill_q <= '0;
			sum_q <= '0;
			sumsq_q <= '0;
			cause_q <= CAUSE_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW_LENGTH: begin
						wl_q <= cfg_data[6:0];
						fill_q <= '0;
						sum_q <= '0;
						sumsq_q <= '0;
					end
					CFG_THRESHOLD: thr_q <= cfg_data;
					CFG_BIG_MOVE_LIMIT: bml_q <= cfg_data[22:0];
					CFG_MIN_RANGE: minr_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
				end
				ST_WAVE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == NW'(DEPTH)) begin
						op_q <= OP_OLD;
						launch_q <= 1'b1;
						cause_q <= CAUSE_NONE;
					end
				end
				ST_MUL: begin
					if (launch_q) begin
						launch_q <= 1'b0;
					end else if (!mul_busy) begin
						case (op_q)
							OP_OLD: begin
								op_q <= OP_XX;
								launch_q <= 1'b1;
							end
							OP_XX: begin
								op_q <= OP_RANGE;
								launch_q <= test_q;
							end
							OP_RANGE: begin
								if (range_hit) begin
									cause_q <= CAUSE_RANGE;
									launch_q <= 1'b0;
								end else begin
									launch_q <= 1'b1;
								end
								op_q <= OP_NSQ;
							end
							OP_NSQ: begin
								op_q <= OP_S2;
								launch_q <= 1'b1;
							end
							OP_S2: begin
								if (nsq_q == prod[VW-1:0]) begin
									cause_q <= big ? CAUSE_BIG : CAUSE_NONE;
									launch_q <= 1'b0;
								end else begin
									launch_q <= 1'b1;
								end
								op_q <= OP_NX;
							end
							OP_NX: begin
								op_q <= OP_D2;
								launch_q <= 1'b1;
							end
							OP_D2: begin
								op_q <= OP_T2;
								launch_q <= 1'b1;
							end
							OP_T2: begin
								op_q <= OP_RHS;
								launch_q <= 1'b1;
							end
							OP_RHS: begin
								launch_q <= 1'b0;
								if (PW'({lhs_q, 32'b0}) > prod) begin
									cause_q <= CAUSE_ZSCORE;
								end else begin
									cause_q <= big ? CAUSE_BIG : CAUSE_NONE;
								end
							end
							default: begin
								op_q <= OP_OLD;
								launch_q <= 1'b1;
							end
						endcase
					end
				end
				ST_FIN: begin
					if (out_free) begin
						fill_q <= n_q + 1'b1;
						sum_q <= sum_a_q + SW'(x_q);
						sumsq_q <= sumsq_a_q + xsq_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && samples.valid) begin
			x_q <= samples.sample;
			n_q <= nfill_w;
			oldi_q <= fill_w - 1'b1;
			drop_q <= drop_w;
			test_q <= (nfill_w >= (len >> 1)) && (nfill_w != '0);
			sum_a_q <= samples.start_series ? '0 : sum_q;
			sumsq_a_q <= samples.start_series ? '0 : sumsq_q;
		end
		if (state_q == ST_WAVE && cnt_q == NW'(DEPTH)) begin
			mx_q <= wv[0].mx;
			mn_q <= wv[0].mn;
			oldm_q <= !drop_q ? '0 : (wv[0].oldv[SampleW-1] ? SampleW'(-wv[0].oldv)
				: SampleW'(wv[0].oldv));
			if (drop_q) begin
				sum_a_q <= sum_a_q - SW'(wv[0].oldv);
			end
		end
		if (mul_done) begin
			case (op_q)
				OP_OLD: sumsq_a_q <= sumsq_a_q - prod[SQW-1:0];
				OP_XX: xsq_q <= prod[SQW-1:0];
				OP_NSQ: nsq_q <= prod[VW-1:0];
				OP_S2: v_q <= nsq_q - prod[VW-1:0];
				OP_NX: d_q <= diff[SW] ? DW'(-diff) : DW'(diff);
				OP_D2: lhs_q <= prod[2*DW-1:0];
				OP_T2: t2_q <= prod[BW-1:0];
				default: begin
				end
			endcase
		end
		if (push) begin
			out_anomaly_q <= cause_q != CAUSE_NONE;
			out_cause_q <= cause_q;
		end
	end

	swaf_mul #(
		.PW(PW),
		.BW(BW)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.busy(mul_busy),
		.prod(prod)
	);

	assign chain[0] = x_q;
	assign wv[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		swaf_cell #(
			.NW(NW),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.shift_en(push),
			.din(chain[i]),
			.dout(chain[i+1]),
			.n(n_q),
			.old_idx(oldi_q),
			.wave_in(wv[i+1]),
			.wave_out(wv[i])
		);
	end

	assign samples.ready = state_q == ST_IDLE;
	assign results.valid = out_valid_q;
	assign results.anomaly = out_anomaly_q;
	assign results.cause = out_cause_q;

endmodule

// ===== hdl/swaf_cell.sv =====
`timescale 1ns / 1ps
module swaf_cell
	import swaf_pkg::*;
#(
	parameter int NW = 7,
	parameter int IDX = 0
) (
	input logic clk,
	input logic shift_en,
	input logic signed [SampleW-1:0] din,
	output logic signed [SampleW-1:0] dout,
	input logic [NW-1:0] n,
	input logic [NW-1:0] old_idx,
	input wave_t wave_in,
	output wave_t wave_out
);

	localparam logic [NW-1:0] MyIdx = NW'(IDX);

	logic signed [SampleW-1:0] sample_q;
	wave_t wave_q;
	wave_t wave_d;

	always_comb begin
		wave_d = wave_in;
		if (MyIdx < n) begin
			if (!wave_in.has || sample_q > wave_in.mx) begin
				wave_d.mx = sample_q;
			end
			if (!wave_in.has || sample_q < wave_in.mn) begin
				wave_d.mn = sample_q;
			end
			wave_d.has = 1'b1;
		end
		if (MyIdx == old_idx) begin
			wave_d.oldv = sample_q;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= din;
		end
		wave_q <= wave_d;
	end

	assign dout = sample_q;
	assign wave_out = wave_q;

endmodule

// ===== hdl/swaf_mul.sv =====
`timescale 1ns / 1ps
module swaf_mul #(
	parameter int PW = 110,
	parameter int BW = 50
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [PW-1:0] a,
	input logic [BW-1:0] b,
	output logic busy,
	output logic [PW-1:0] prod
);

	logic [PW-1:0] a_sh_q;
	logic [BW-1:0] b_sh_q;
	logic [PW-1:0] acc_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_sh_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_sh_q <= a;
			b_sh_q <= b;
		end else if (busy_q && b_sh_q != '0) begin
			if (b_sh_q[0]) begin
				acc_q <= acc_q + a_sh_q;
			end
			a_sh_q <= a_sh_q << 1;
			b_sh_q <= b_sh_q >> 1;
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule
